// File: sv/csup_pkg.sv
// Shared types, constants and helpers for the charger supervisor.
`default_nettype none

package csup_pkg;

    localparam int TEMP_W = 12;
    localparam int VOLT_W = 16;
    localparam int TICK_W = 16;
    localparam int COUNT_W = 8;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        MODE_INIT      = 2'd0,
        MODE_RUNNING   = 2'd1,
        MODE_ERROR     = 2'd2,
        MODE_LOW_POWER = 2'd3
    } mode_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_TEMP_LIMIT     = 3'd0,
        CFG_SOLAR_MIN      = 3'd1,
        CFG_CHECK_INTERVAL = 3'd2,
        CFG_ERROR_WAIT     = 3'd3,
        CFG_LOW_POWER_WAIT = 3'd4,
        CFG_MAX_ERRORS     = 3'd5
    } cfg_index_t;

    localparam logic signed [TEMP_W-1:0] TEMP_LIMIT_RESET = 12'sd750;
    localparam logic [VOLT_W-1:0] SOLAR_MIN_RESET = 16'd5000;
    localparam logic [TICK_W-1:0] CHECK_INTERVAL_RESET = 16'd3000;
    localparam logic [TICK_W-1:0] ERROR_WAIT_RESET = 16'd5000;
    localparam logic [TICK_W-1:0] LOW_POWER_WAIT_RESET = 16'd10000;
    localparam logic [COUNT_W-1:0] MAX_ERRORS_RESET = 8'd5;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_limit;
        logic [VOLT_W-1:0]        solar_min;
        logic [TICK_W-1:0]        check_interval;
        logic [TICK_W-1:0]        error_wait;
        logic [TICK_W-1:0]        low_power_wait;
        logic [COUNT_W-1:0]       max_errors;
    } cfg_t;

    typedef struct packed {
        mode_t              mode;
        logic [TICK_W-1:0]  check_timer;
        logic [TICK_W-1:0]  wait_timer;
        logic [COUNT_W-1:0] fault_count;
        logic               error_armed;
        logic               low_power_armed;
    } state_t;

    typedef struct packed {
        mode_t              mode;
        logic               tracker_start;
        logic               tracker_stop;
        logic               mppt_step;
        logic               reset_request;
        logic [COUNT_W-1:0] error_count;
    } result_t;

    localparam state_t STATE_RESET = '{
        mode:            MODE_INIT,
        check_timer:     '0,
        wait_timer:      '0,
        fault_count:     '0,
        error_armed:     1'b1,
        low_power_armed: 1'b1
    };

    function automatic logic [TICK_W-1:0] sat_inc16(input logic [TICK_W-1:0] v);
        return (v == {TICK_W{1'b1}}) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// File: sv/csup_cfg_regs.sv
// Configuration register bank of the charger supervisor.
`default_nettype none

module csup_cfg_regs (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write_en,
    input  wire logic [csup_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [csup_pkg::CFG_DATA_W-1:0]     cfg_data,
    output csup_pkg::cfg_t                           cfg
);

    csup_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.temp_limit     <= csup_pkg::TEMP_LIMIT_RESET;
            cfg_reg.solar_min      <= csup_pkg::SOLAR_MIN_RESET;
            cfg_reg.check_interval <= csup_pkg::CHECK_INTERVAL_RESET;
            cfg_reg.error_wait     <= csup_pkg::ERROR_WAIT_RESET;
            cfg_reg.low_power_wait <= csup_pkg::LOW_POWER_WAIT_RESET;
            cfg_reg.max_errors     <= csup_pkg::MAX_ERRORS_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                csup_pkg::CFG_TEMP_LIMIT:
                    cfg_reg.temp_limit <= $signed(cfg_data[csup_pkg::TEMP_W-1:0]);
                csup_pkg::CFG_SOLAR_MIN:
                    cfg_reg.solar_min <= cfg_data[csup_pkg::VOLT_W-1:0];
                csup_pkg::CFG_CHECK_INTERVAL:
                    cfg_reg.check_interval <= cfg_data[csup_pkg::TICK_W-1:0];
                csup_pkg::CFG_ERROR_WAIT:
                    cfg_reg.error_wait <= cfg_data[csup_pkg::TICK_W-1:0];
                csup_pkg::CFG_LOW_POWER_WAIT:
                    cfg_reg.low_power_wait <= cfg_data[csup_pkg::TICK_W-1:0];
                csup_pkg::CFG_MAX_ERRORS:
                    cfg_reg.max_errors <= cfg_data[csup_pkg::COUNT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: sv/csup_step.sv
// Per-tick check and mode step: next supervisor state and result of one item.
`default_nettype none

module csup_step (
    input  wire csup_pkg::cfg_t                         cfg,
    input  wire csup_pkg::state_t                       state,
    input  wire logic signed [csup_pkg::TEMP_W-1:0]     temperature,
    input  wire logic [csup_pkg::VOLT_W-1:0]            solar_mv,
    output csup_pkg::state_t                            state_next,
    output csup_pkg::result_t                           result
);

    always_comb
    begin
        csup_pkg::state_t s;
        logic start;
        logic stop;
        logic step;
        logic rst;

        s = state;
        start = 1'b0;
        stop = 1'b0;
        step = 1'b0;
        rst = 1'b0;

        s.check_timer = csup_pkg::sat_inc16(s.check_timer);
        if (s.check_timer >= cfg.check_interval)
        begin
            s.check_timer = '0;
            if ($signed(temperature) > $signed(cfg.temp_limit))
            begin
                s.mode = csup_pkg::MODE_ERROR;
                if (s.fault_count != {csup_pkg::COUNT_W{1'b1}})
                begin
                    s.fault_count = s.fault_count + 1'b1;
                end
            end
            else if (solar_mv < cfg.solar_min)
            begin
                s.mode = csup_pkg::MODE_LOW_POWER;
            end
            else if (s.mode != csup_pkg::MODE_RUNNING)
            begin
                s.mode = csup_pkg::MODE_RUNNING;
                s.error_armed = 1'b1;
                s.low_power_armed = 1'b1;
                start = 1'b1;
            end
        end

        unique case (s.mode)
            csup_pkg::MODE_INIT:
            begin
                s.mode = csup_pkg::MODE_RUNNING;
            end
            csup_pkg::MODE_RUNNING:
            begin
                step = 1'b1;
            end
            csup_pkg::MODE_ERROR:
            begin
                if (s.error_armed)
                begin
                    stop = 1'b1;
                    s.wait_timer = '0;
                    s.error_armed = 1'b0;
                end
                else
                begin
                    s.wait_timer = csup_pkg::sat_inc16(s.wait_timer);
                end
                if (s.wait_timer >= cfg.error_wait)
                begin
                    if (s.fault_count > cfg.max_errors)
                    begin
                        rst = 1'b1;
                        s = csup_pkg::STATE_RESET;
                    end
                    else
                    begin
                        s.mode = csup_pkg::MODE_INIT;
                        s.error_armed = 1'b1;
                    end
                end
            end
            csup_pkg::MODE_LOW_POWER:
            begin
                if (s.low_power_armed)
                begin
                    stop = 1'b1;
                    s.wait_timer = '0;
                    s.low_power_armed = 1'b0;
                end
                else
                begin
                    s.wait_timer = csup_pkg::sat_inc16(s.wait_timer);
                end
                if (s.wait_timer >= cfg.low_power_wait)
                begin
                    s.mode = csup_pkg::MODE_INIT;
                    s.low_power_armed = 1'b1;
                end
            end
        endcase

        state_next = s;
        result.mode = s.mode;
        result.tracker_start = start;
        result.tracker_stop = stop;
        result.mppt_step = step;
        result.reset_request = rst;
        result.error_count = s.fault_count;
    end

endmodule

`default_nettype wire

// File: sv/charger_supervisor_fsm.sv
// Top level of the charger supervisor: input register, state, result register.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------------------
//  input    | in_valid / in_ready      | temperature, solar_mv
//  result   | out_valid / out_ready    | mode, tracker_start, tracker_stop, mppt_step,
//           |                          | reset_request, error_count
//  config   | cfg_write_en             | cfg_index, cfg_data
//
// One item per cycle sustained while out_ready holds; each accepted item passes from the input
// register through the combinational mode step into the result register.
// The supervisor state advances only when an item moves into the result register.
// A stalled result holds its register; the input register still takes one more item.
// Reset restores the configuration defaults and the init state at once.
`default_nettype none

module charger_supervisor_fsm (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output wire logic                                in_ready,
    input  wire logic signed [csup_pkg::TEMP_W-1:0]  temperature,
    input  wire logic [csup_pkg::VOLT_W-1:0]         solar_mv,
    output wire logic                                out_valid,
    input  wire logic                                out_ready,
    output wire logic [1:0]                          mode,
    output wire logic                                tracker_start,
    output wire logic                                tracker_stop,
    output wire logic                                mppt_step,
    output wire logic                                reset_request,
    output wire logic [csup_pkg::COUNT_W-1:0]        error_count,
    input  wire logic                                cfg_write_en,
    input  wire logic [csup_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [csup_pkg::CFG_DATA_W-1:0]     cfg_data
);

    csup_pkg::cfg_t    cfg;
    csup_pkg::state_t  state_reg;
    csup_pkg::state_t  state_next;
    csup_pkg::result_t result_next;
    csup_pkg::result_t result_reg;

    logic                              in_valid_reg;
    logic signed [csup_pkg::TEMP_W-1:0] temp_reg;
    logic [csup_pkg::VOLT_W-1:0]        solar_reg;
    logic                              out_valid_reg;
    logic                              advance;

    csup_cfg_regs u_cfg_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    csup_step u_step (
        .cfg         (cfg),
        .state       (state_reg),
        .temperature (temp_reg),
        .solar_mv    (solar_reg),
        .state_next  (state_next),
        .result      (result_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            temp_reg  <= temperature;
            solar_reg <= solar_mv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csup_pkg::STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mode          = result_reg.mode;
    assign tracker_start = result_reg.tracker_start;
    assign tracker_stop  = result_reg.tracker_stop;
    assign mppt_step     = result_reg.mppt_step;
    assign reset_request = result_reg.reset_request;
    assign error_count   = result_reg.error_count;

    a_reset_clears : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reset_request |-> mode == csup_pkg::MODE_INIT && error_count == '0)
        else $error("reset request without cleared mode and count");

    a_start_running : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && tracker_start |-> mode == csup_pkg::MODE_RUNNING && mppt_step)
        else $error("start pulse outside running mode");

    a_step_excl_stop : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mppt_step |-> mode == csup_pkg::MODE_RUNNING && !tracker_stop)
        else $error("step pulse with stop or outside running mode");

    a_state_holds : assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("supervisor state moved without an item");

    a_result_matches_state : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid && mode == state_reg.mode
                    && error_count == state_reg.fault_count)
        else $error("result register disagrees with committed state");

endmodule

`default_nettype wire
